// ===== hw/rtl/sh24_pkg.sv =====
// ----------------------------------------------------------------------------
// sh24_pkg
// Types, constants and the SipRound function of the SipHash-2-4 engine.
// ----------------------------------------------------------------------------
package sh24_pkg;

	localparam int COMPRESS_ROUNDS = 2;
	localparam int FINAL_ROUNDS    = 4;
	localparam int CNT_W           = 3;

	localparam int WORD_W  = 64;
	localparam int TAIL_W  = 3;
	localparam int TOTAL_W = 8;
	localparam int LANES   = 4;

	typedef logic [WORD_W-1:0]             word_t;
	typedef logic [TAIL_W-1:0]             tail_t;
	typedef logic [TOTAL_W-1:0]            total_t;
	typedef logic [LANES-1:0][WORD_W-1:0]  lanes_t;
	typedef logic [CNT_W-1:0]              cnt_t;

	// configuration register indexes
	localparam logic CFG_KEY_LOW  = 1'b0;
	localparam logic CFG_KEY_HIGH = 1'b1;

	localparam word_t IV0 = 64'h736f6d6570736575;
	localparam word_t IV1 = 64'h646f72616e646f6d;
	localparam word_t IV2 = 64'h6c7967656e657261;
	localparam word_t IV3 = 64'h7465646279746573;

	localparam word_t  FINAL_XOR  = 64'h00000000000000ff;
	localparam total_t WORD_BYTES = 8'd8;

	localparam int ROT_A = 13;
	localparam int ROT_B = 32;
	localparam int ROT_C = 16;
	localparam int ROT_D = 21;
	localparam int ROT_E = 17;

	function automatic word_t rotl(input word_t x, input int r);
		rotl = (x << r) | (x >> (WORD_W - r));
	endfunction

	// one SipRound over the four lanes
	function automatic lanes_t sip_round(input lanes_t v_in);
		lanes_t v;
		v = v_in;
		v[0] = v[0] + v[1];
		v[1] = rotl(v[1], ROT_A) ^ v[0];
		v[0] = rotl(v[0], ROT_B);
		v[2] = v[2] + v[3];
		v[3] = rotl(v[3], ROT_C) ^ v[2];
		v[0] = v[0] + v[3];
		v[3] = rotl(v[3], ROT_D) ^ v[0];
		v[2] = v[2] + v[1];
		v[1] = rotl(v[1], ROT_E) ^ v[2];
		v[2] = rotl(v[2], ROT_B);
		sip_round = v;
	endfunction

endpackage

// ===== hw/rtl/sh24_in_if.sv =====
// ----------------------------------------------------------------------------
// sh24_in_if
// Message word channel: valid/ready with word, tail byte count and last flag.
// ----------------------------------------------------------------------------
interface sh24_in_if;
	import sh24_pkg::*;

	logic  valid;
	logic  ready;
	word_t message_word;
	tail_t tail_bytes;
	logic  last;

	modport source (output valid, output message_word, output tail_bytes,
		output last, input ready);
	modport sink (input valid, input message_word, input tail_bytes,
		input last, output ready);
endinterface

// ===== hw/rtl/sh24_out_if.sv =====
// ----------------------------------------------------------------------------
// sh24_out_if
// Hash result channel: valid/ready with the 64-bit hash.
// ----------------------------------------------------------------------------
interface sh24_out_if;
	import sh24_pkg::*;

	logic  valid;
	logic  ready;
	word_t hash_value;

	modport source (output valid, output hash_value, input ready);
	modport sink (input valid, input hash_value, output ready);
endinterface

// ===== hw/rtl/siphash_2_4_engine.sv =====
// A full word takes COMPRESS_ROUNDS SipRounds, one SipRound a cycle. A last
// word takes COMPRESS_ROUNDS + FINAL_ROUNDS; the last final round is held
// until the output slot is free, when the hash goes into the output register.
// Throughput is set by the single shared SipRound unit; in_ch.ready is low
// while a word is being mixed. Reset clears the keys and lanes, and the
// next accepted word starts a new message.
// ----------------------------------------------------------------------------
// siphash_2_4_engine
// Keyed SipHash-2-4 over a stream of 64-bit little-endian message words.
// ----------------------------------------------------------------------------
module siphash_2_4_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  sh24_pkg::word_t   cfg_data,
	sh24_in_if.sink           in_ch,
	sh24_out_if.source        out_ch
);
	import sh24_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COMPRESS,
		ST_FINAL
	} state_t;

	state_t state_q;
	word_t  key_low_q;
	word_t  key_high_q;
	lanes_t lanes_q;
	word_t  m_q;
	logic   last_q;
	total_t byte_total_q;
	logic   msg_start_q;
	cnt_t   cnt_q;
	logic   out_valid_q;
	word_t  hash_q;

	logic   accept;
	logic   idle;
	total_t total_new;
	word_t  m_acc;
	lanes_t start_lanes;
	lanes_t rnd_in;
	lanes_t rnd_out;
	lanes_t fin_lanes;
	word_t  m_cur;
	logic   last_cur;
	word_t  hash_new;
	logic   cmp_last;
	logic   fin_last;
	logic   out_free;

	assign idle        = (state_q == ST_IDLE);
	assign in_ch.ready = idle;
	assign accept      = in_ch.valid & in_ch.ready;

	assign out_ch.valid      = out_valid_q;
	assign out_ch.hash_value = hash_q;
	assign out_free          = ~out_valid_q | out_ch.ready;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_LOW:  key_low_q  <= cfg_data;
				CFG_KEY_HIGH: key_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		total_new = (msg_start_q ? '0 : byte_total_q)
			+ (in_ch.last ? {{(TOTAL_W-TAIL_W){1'b0}}, in_ch.tail_bytes} : WORD_BYTES);

		// tail packing: keep the low tail bytes, length byte on top
		m_acc = in_ch.message_word;
		if (in_ch.last) begin
			for (int i = 0; i < 8; i++) begin
				if (TAIL_W'(i) >= in_ch.tail_bytes) begin
					m_acc[8*i +: 8] = 8'h00;
				end
			end
			m_acc[WORD_W-1 -: TOTAL_W] = total_new;
		end

		if (msg_start_q) begin
			start_lanes[0] = key_low_q ^ IV0;
			start_lanes[1] = key_high_q ^ IV1;
			start_lanes[2] = key_low_q ^ IV2;
			start_lanes[3] = key_high_q ^ IV3;
		end else begin
			start_lanes = lanes_q;
		end

		rnd_in = lanes_q;
		if (idle) begin
			rnd_in    = start_lanes;
			rnd_in[3] = start_lanes[3] ^ m_acc;
		end
		rnd_out = sip_round(rnd_in);

		m_cur    = idle ? m_acc : m_q;
		last_cur = idle ? in_ch.last : last_q;

		fin_lanes    = rnd_out;
		fin_lanes[0] = rnd_out[0] ^ m_cur;
		if (last_cur) begin
			fin_lanes[2] = rnd_out[2] ^ FINAL_XOR;
		end

		hash_new = rnd_out[0] ^ rnd_out[1] ^ rnd_out[2] ^ rnd_out[3];

		cmp_last = idle ? (COMPRESS_ROUNDS == 1) : (cnt_q == CNT_W'(COMPRESS_ROUNDS - 1));
		fin_last = (cnt_q == CNT_W'(FINAL_ROUNDS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			lanes_q      <= '0;
			m_q          <= '0;
			last_q       <= 1'b0;
			byte_total_q <= '0;
			msg_start_q  <= 1'b1;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			hash_q       <= '0;
		end else begin
			// a new hash on the last final round keeps the slot full
			if (out_ch.ready && !(state_q == ST_FINAL && fin_last)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						byte_total_q <= total_new;
						msg_start_q  <= 1'b0;
						m_q          <= m_acc;
						last_q       <= in_ch.last;
						if (cmp_last) begin
							lanes_q <= fin_lanes;
							cnt_q   <= '0;
							state_q <= in_ch.last ? ST_FINAL : ST_IDLE;
						end else begin
							lanes_q <= rnd_out;
							cnt_q   <= CNT_W'(1);
							state_q <= ST_COMPRESS;
						end
					end
				end
				ST_COMPRESS: begin
					if (cmp_last) begin
						lanes_q <= fin_lanes;
						cnt_q   <= '0;
						state_q <= last_q ? ST_FINAL : ST_IDLE;
					end else begin
						lanes_q <= rnd_out;
						cnt_q   <= cnt_q + CNT_W'(1);
					end
				end
				ST_FINAL: begin
					if (fin_last) begin
						// hold on the last round until the output slot frees up
						if (out_free) begin
							hash_q      <= hash_new;
							out_valid_q <= 1'b1;
							msg_start_q <= 1'b1;
							cnt_q       <= '0;
							state_q     <= ST_IDLE;
						end
					end else begin
						lanes_q <= rnd_out;
						cnt_q   <= cnt_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_hash_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINAL))
		else $error("hash word raised outside finalization");

	a_final_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINAL |-> last_q)
		else $error("finalization entered for a non-last word");

	a_compress_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COMPRESS |-> cnt_q < COMPRESS_ROUNDS)
		else $error("compression round count overran");

	a_new_msg_after_hash: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> msg_start_q)
		else $error("message start not set after hash");

endmodule
